// ----- rtl/km2d_pkg.sv -----
// Package for the 2-D k-means clustering block.
// Holds the sequencer state type and the configuration index constants; no dependencies.
`default_nettype none
package km2d_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEED_RD,
        ST_SEED,
        ST_ASSIGN_RD,
        ST_ASSIGN_DIST,
        ST_ASSIGN_CMP,
        ST_UPD_CLEAR,
        ST_UPD_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT
    } km2d_state_t;

    localparam logic CFG_CLUSTER_COUNT = 1'b0;
    localparam logic CFG_ITERATION_COUNT = 1'b1;

endpackage
`default_nettype wire

// ----- rtl/km2d_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module km2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/km2d_div.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// No dependencies.
`default_nettype none
module km2d_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic        [DEN_W-1:0] den,
    output logic                         busy,
    output logic signed [NUM_W-1:0]      quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic [NUM_W-1:0] mag;

    assign mag     = num[NUM_W-1] ? NUM_W'(-num) : num;
    assign shifted = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign busy    = busy_reg;
    assign quo     = neg_reg ? NUM_W'(-q_reg) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/km2d_dist.sv -----
// Squared-distance unit: one point against one centroid, registered product stage.
// Depends on nothing; used by the top-level sequencer.
`default_nettype none
module km2d_dist #(
    parameter int CW = 16
) (
    input  wire logic                 clk,
    input  wire logic signed [CW-1:0] px,
    input  wire logic signed [CW-1:0] py,
    input  wire logic signed [CW-1:0] cx,
    input  wire logic signed [CW-1:0] cy,
    output logic             [2*CW+2:0] dist_sq
);
    logic [CW:0]     dx;
    logic [CW:0]     dy;
    logic [2*CW+1:0] sx_reg;
    logic [2*CW+1:0] sy_reg;

    always_comb
    begin
        logic signed [CW:0] ddx;
        logic signed [CW:0] ddy;
        ddx = (CW+1)'(px) - (CW+1)'(cx);
        ddy = (CW+1)'(py) - (CW+1)'(cy);
        dx  = ddx[CW] ? (CW+1)'(-ddx) : ddx;
        dy  = ddy[CW] ? (CW+1)'(-ddy) : ddy;
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= dx * dx;
        sy_reg <= dy * dy;
    end

    assign dist_sq = (2*CW+3)'(sx_reg) + (2*CW+3)'(sy_reg);
endmodule
`default_nettype wire

// ----- rtl/kmeans_2d_clustering_top.sv -----
// Top level of the 2-D k-means clustering block: sequencer, point and label RAMs.
// Depends on km2d_pkg, km2d_ram, km2d_dist and km2d_div.
//
// Points load one beat per cycle while s_axis_tready is high. The beat with
// tlast starts a Lloyd run of iteration_count passes after a seed sweep. Each
// pass runs every point through the single distance unit (one read per point,
// then square and compare per centroid), clears and accumulates the sums, and
// per cluster either skips the update when it is empty or runs two divisions,
// x then y, in the shared serial divider. Then n result beats follow, each read
// from the RAMs before it is offered on m_axis_tvalid.
// s_axis_tready is low from the final beat until the last result is taken.
`default_nettype none
module kmeans_2d_clustering_top
    import km2d_pkg::*;
#(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_CLUSTERS = 8,
    parameter int COORD_WIDTH  = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [2*COORD_WIDTH-1:0] s_axis_tdata,  // coord_x, coord_y
    input  wire logic                     s_axis_tlast,  // final_point
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [((2*COORD_WIDTH+3+7)/8)*8-1:0] m_axis_tdata, // out_x, out_y, cluster
    output logic                          m_axis_tlast,  // end_of_set
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_index,
    input  wire logic [7:0]               cfg_data
);
    localparam int CW    = COORD_WIDTH;
    localparam int PW    = $clog2(MAX_POINTS);
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int KW    = $clog2(MAX_CLUSTERS);
    localparam int KNW   = $clog2(MAX_CLUSTERS + 1);
    localparam int SW    = CW + NW;
    localparam int DW    = 2*CW + 3;
    localparam int OUT_W = ((2*CW + 3 + 7) / 8) * 8;

    km2d_state_t state_reg, state_next;

    logic [3:0]  k_cfg_reg;
    logic [7:0]  it_cfg_reg;
    logic [NW-1:0]  n_reg, n_next;
    logic [KNW-1:0] k_reg, k_next;
    logic [7:0]     it_reg, it_next;
    logic [NW-1:0]  p_reg, p_next;
    logic [KNW-1:0] c_reg, c_next;
    logic [KW-1:0]  best_reg, best_next;
    logic [DW-1:0]  bestd_reg, bestd_next;
    logic           axis_reg, axis_next;
    logic           lbl_valid_reg;

    logic signed [CW-1:0] cx_reg [MAX_CLUSTERS];
    logic signed [CW-1:0] cy_reg [MAX_CLUSTERS];
    logic signed [SW-1:0] sx_reg [MAX_CLUSTERS];
    logic signed [SW-1:0] sy_reg [MAX_CLUSTERS];
    logic [NW-1:0]        mc_reg [MAX_CLUSTERS];

    logic             pt_we, lb_we;
    logic [PW-1:0]    pt_waddr, pt_raddr, lb_waddr;
    logic [2*CW-1:0]  pt_wdata, pt_rdata;
    logic [KW-1:0]    lb_wdata, lb_rdata;
    logic [DW-1:0]    dist_sq;
    logic             div_start, div_busy;
    logic signed [SW-1:0] div_num, div_quo;
    logic [NW-1:0]    div_den;
    logic             in_acc, out_acc;
    logic [KW-1:0]    cidx;

    assign cidx = c_reg[KW-1:0];

    km2d_ram #(.WIDTH(2*CW), .DEPTH(MAX_POINTS)) u_pts (
        .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .raddr(pt_raddr), .rdata(pt_rdata)
    );

    km2d_ram #(.WIDTH(KW), .DEPTH(MAX_POINTS)) u_lbl (
        .clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
        .raddr(pt_raddr), .rdata(lb_rdata)
    );

    km2d_dist #(.CW(CW)) u_dist (
        .clk(clk),
        .px(pt_rdata[CW-1:0]), .py(pt_rdata[2*CW-1:CW]),
        .cx(cx_reg[cidx]), .cy(cy_reg[cidx]),
        .dist_sq(dist_sq)
    );

    km2d_div #(.NUM_W(SW), .DEN_W(NW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo)
    );

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign cfg_ready     = (state_reg == ST_LOAD);
    assign m_axis_tdata  = OUT_W'({(lbl_valid_reg ? lb_wdata_hold(lb_rdata) : 3'd0),
                                   pt_rdata});
    assign m_axis_tlast  = (p_reg == n_reg - 1'b1);

    function automatic logic [2:0] lb_wdata_hold(input logic [KW-1:0] v);
        lb_wdata_hold = 3'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_cfg_reg  <= 4'd2;
            it_cfg_reg <= 8'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLUSTER_COUNT:   k_cfg_reg  <= cfg_data[3:0];
                CFG_ITERATION_COUNT: it_cfg_reg <= cfg_data;
                default:             k_cfg_reg  <= k_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            k_reg     <= '0;
            it_reg    <= '0;
            p_reg     <= '0;
            c_reg     <= '0;
            best_reg  <= '0;
            bestd_reg <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            it_reg    <= it_next;
            p_reg     <= p_next;
            c_reg     <= c_next;
            best_reg  <= best_next;
            bestd_reg <= bestd_next;
            axis_reg  <= axis_next;
        end
    end

    // centroid, sum and count registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEED)
        begin
            cx_reg[cidx] <= pt_rdata[CW-1:0];
            cy_reg[cidx] <= pt_rdata[2*CW-1:CW];
        end
        if (state_reg == ST_UPD_CLEAR)
        begin
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                mc_reg[i] <= '0;
            end
        end
        if (state_reg == ST_UPD_ACC && p_reg != '0)
        begin
            sx_reg[lb_rdata] <= sx_reg[lb_rdata] + SW'(signed'(pt_rdata[CW-1:0]));
            sy_reg[lb_rdata] <= sy_reg[lb_rdata] + SW'(signed'(pt_rdata[2*CW-1:CW]));
            mc_reg[lb_rdata] <= mc_reg[lb_rdata] + 1'b1;
        end
        if (state_reg == ST_DIV_WAIT && !div_busy && !div_start)
        begin
            if (!axis_reg)
            begin
                cx_reg[cidx] <= div_quo[CW-1:0];
            end
            else
            begin
                cy_reg[cidx] <= div_quo[CW-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        it_next    = it_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;
        axis_next  = axis_reg;
        pt_we      = 1'b0;
        pt_waddr   = n_reg[PW-1:0];
        pt_wdata   = s_axis_tdata;
        pt_raddr   = p_reg[PW-1:0];
        lb_we      = 1'b0;
        lb_waddr   = p_reg[PW-1:0];
        lb_wdata   = '0;
        div_start  = 1'b0;
        div_num    = axis_reg ? sy_reg[cidx] : sx_reg[cidx];
        div_den    = mc_reg[cidx];

        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (n_reg < NW'(MAX_POINTS))
                    begin
                        pt_we  = 1'b1;
                        n_next = n_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        if (n_reg < NW'(MAX_POINTS) || n_reg != '0)
                        begin
                            if (k_cfg_reg == 4'd0)
                                k_next = KNW'(1);
                            else if (32'(k_cfg_reg) > MAX_CLUSTERS)
                                k_next = KNW'(MAX_CLUSTERS);
                            else
                                k_next = KNW'(k_cfg_reg);
                            it_next    = it_cfg_reg;
                            c_next     = '0;
                            p_next     = '0;
                            state_next = ST_SEED_RD;
                        end
                    end
                end
            end
            ST_SEED_RD:
            begin
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                // read of point p lands this cycle
                pt_raddr = p_reg[PW-1:0];
                if (c_reg + 1'b1 == k_reg)
                begin
                    p_next     = '0;
                    c_next     = '0;
                    state_next = (it_reg == '0) ? ST_EMIT_RD : ST_ASSIGN_RD;
                end
                else
                begin
                    c_next   = c_reg + 1'b1;
                    p_next   = (p_reg + 1'b1 == n_reg) ? '0 : p_reg + 1'b1;
                    pt_raddr = ((p_reg + 1'b1 == n_reg) ? '0 : p_reg[PW-1:0] + 1'b1);
                end
            end
            ST_ASSIGN_RD:
            begin
                state_next = ST_ASSIGN_DIST;
            end
            ST_ASSIGN_DIST:
            begin
                state_next = ST_ASSIGN_CMP;
            end
            ST_ASSIGN_CMP:
            begin
                if (c_reg == '0 || dist_sq < bestd_reg)
                begin
                    bestd_next = dist_sq;
                    best_next  = cidx;
                end
                if (c_reg + 1'b1 == k_reg)
                begin
                    lb_we    = 1'b1;
                    lb_wdata = (c_reg == '0 || dist_sq < bestd_reg) ? cidx : best_reg;
                    c_next   = '0;
                    if (p_reg + 1'b1 == n_reg)
                    begin
                        p_next     = '0;
                        state_next = ST_UPD_CLEAR;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_ASSIGN_RD;
                    end
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_ASSIGN_DIST;
                end
            end
            ST_UPD_CLEAR:
            begin
                state_next = ST_UPD_ACC;
            end
            ST_UPD_ACC:
            begin
                // data of point p-1 is valid here
                pt_raddr = p_reg[PW-1:0];
                if (p_reg == n_reg)
                begin
                    p_next     = '0;
                    c_next     = '0;
                    axis_next  = 1'b0;
                    state_next = ST_DIV_START;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
                if (p_reg == n_reg)
                    pt_raddr = '0;
            end
            ST_DIV_START:
            begin
                if (mc_reg[cidx] != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
                else if (c_reg + 1'b1 == k_reg)
                begin
                    c_next     = '0;
                    it_next    = it_reg - 1'b1;
                    state_next = (it_reg == 8'd1) ? ST_EMIT_RD : ST_ASSIGN_RD;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = ST_DIV_START;
                    end
                    else
                    begin
                        axis_next = 1'b0;
                        if (c_reg + 1'b1 == k_reg)
                        begin
                            c_next     = '0;
                            it_next    = it_reg - 1'b1;
                            state_next = (it_reg == 8'd1) ? ST_EMIT_RD : ST_ASSIGN_RD;
                        end
                        else
                        begin
                            c_next     = c_reg + 1'b1;
                            state_next = ST_DIV_START;
                        end
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (p_reg + 1'b1 == n_reg)
                    begin
                        p_next     = '0;
                        n_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // report cluster 0 for every point when no pass runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lbl_valid_reg <= 1'b0;
        else if (state_reg == ST_SEED)
            lbl_valid_reg <= (it_reg != '0);
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while results pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_START) |-> !div_busy)
        else $error("divider started while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (n_reg != '0))
        else $error("emitting an empty set");

endmodule
`default_nettype wire
